// File: hdl/xmdu_pkg.sv
// Types and constants for the x86 multiply/divide unit.
// Used by xmdu_div_step and x86_multiply_divide_unit; depends on nothing.
package xmdu_pkg;

    localparam int NSTEP = 17;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_IMUL = 2'd1,
        OP_DIV  = 2'd2,
        OP_IDIV = 2'd3
    } op_t;

    localparam int FL_CF = 0;
    localparam int FL_PF = 2;
    localparam int FL_AF = 4;
    localparam int FL_ZF = 6;
    localparam int FL_SF = 7;
    localparam int FL_OF = 11;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] acc_in;
        logic [15:0] ext_in;
        logic [15:0] source;
        logic        word_size;
        logic [15:0] flags_in;
    } item_t;

    typedef struct packed {
        logic [15:0] acc_out;
        logic [15:0] ext_out;
        logic [15:0] flags_out;
        logic        divide_error;
    } result_t;

    // Control carried alongside the divider through every stage
    typedef struct packed {
        op_t         op;
        logic        wide;
        logic [15:0] ax;
        logic [15:0] dx;
        logic [15:0] flags;
        logic [31:0] prod;
        logic        dneg;
        logic        vneg;
        logic        bad;
    } ctl_t;

    // Partial remainder, unconsumed dividend bits, quotient, divisor magnitude
    typedef struct packed {
        logic [15:0] rem;
        logic [16:0] dsh;
        logic [16:0] quo;
        logic [15:0] vm;
    } div_t;

endpackage

// File: hdl/x86_multiply_divide_unit.sv
// Top level of the x86 MUL/IMUL/DIV/IDIV unit.
// Depends on xmdu_pkg and xmdu_div_step.
//
// Usage:
//   Drive item and raise start for one cycle per instruction. busy is always
//   low, so a beat is taken on every edge at which start is high.
//   The result appears on result with done high for exactly one cycle.
// Pipeline: the input register, 17 restoring-division steps (one quotient
//   bit each), and the output register. The 17x17 multiplier and the overflow
//   pre-check sit in front of the first division step. The division step
//   chain sets the depth.
// Throughput: one instruction per cycle, multiplies and divides alike; every
//   instruction takes the same path so results leave in order.
// Reset: rst_n clears all valid bits; instructions in flight are dropped and
//   done stays low until a new beat has travelled through.
// The receiver cannot stall: the result is shown for one cycle only.
// Flags and the divide-error mark follow x86 rules; on a divide error AX, DX
//   and the flags come back unchanged.
module x86_multiply_divide_unit
    import xmdu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result
);

    // Input stage
    logic        a_valid_reg;
    ctl_t        a_ctl_reg;
    logic [31:0] a_dm_reg;
    logic [15:0] a_vm_reg;
    logic [16:0] a_ma_reg;
    logic [16:0] a_mb_reg;

    ctl_t        a_ctl_next;
    logic [31:0] a_dm_next;
    logic [15:0] a_vm_next;
    logic [16:0] a_ma_next;
    logic [16:0] a_mb_next;
    logic [31:0] dd;
    logic [31:0] dv;
    logic        sgn;

    assign busy = 1'b0;
    assign sgn  = item.operation[0];

    // Sign or zero extend operands, take divide magnitudes
    always_comb
    begin
        a_ctl_next       = '0;
        a_ctl_next.op    = op_t'(item.operation);
        a_ctl_next.wide  = item.word_size;
        a_ctl_next.ax    = item.acc_in;
        a_ctl_next.dx    = item.ext_in;
        a_ctl_next.flags = item.flags_in;
        if (item.word_size)
        begin
            a_ma_next = {sgn & item.acc_in[15], item.acc_in};
            a_mb_next = {sgn & item.source[15], item.source};
            dd = {item.ext_in, item.acc_in};
            dv = {{16{sgn & item.source[15]}}, item.source};
        end
        else
        begin
            a_ma_next = {{9{sgn & item.acc_in[7]}}, item.acc_in[7:0]};
            a_mb_next = {{9{sgn & item.source[7]}}, item.source[7:0]};
            dd = {{16{sgn & item.acc_in[15]}}, item.acc_in};
            dv = {{24{sgn & item.source[7]}}, item.source[7:0]};
        end
        a_ctl_next.dneg = sgn & dd[31];
        a_ctl_next.vneg = sgn & dv[31];
        a_dm_next = a_ctl_next.dneg ? (32'd0 - dd) : dd;
        a_vm_next = a_ctl_next.vneg ? 16'(32'd0 - dv) : dv[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        a_ctl_reg <= a_ctl_next;
        a_dm_reg  <= a_dm_next;
        a_vm_reg  <= a_vm_next;
        a_ma_reg  <= a_ma_next;
        a_mb_reg  <= a_mb_next;
    end

    // Operand stage: multiply and quotient overflow pre-check
    logic signed [33:0] prod_full;
    ctl_t               s0_ctl;
    div_t               s0_div;

    always_comb
    begin
        prod_full     = $signed(a_ma_reg) * $signed(a_mb_reg);
        s0_ctl        = a_ctl_reg;
        s0_ctl.prod   = prod_full[31:0];
        s0_ctl.bad    = (a_vm_reg == 16'd0) || ({1'b0, a_dm_reg[31:17]} >= a_vm_reg);
        s0_div.rem    = {1'b0, a_dm_reg[31:17]};
        s0_div.dsh    = a_dm_reg[16:0];
        s0_div.quo    = '0;
        s0_div.vm     = a_vm_reg;
    end

    // Division step chain
    logic        s_valid [NSTEP];
    ctl_t        s_ctl   [NSTEP];
    div_t        s_div   [NSTEP];

    xmdu_div_step u_step0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (a_valid_reg),
        .ctl_in    (s0_ctl),
        .div_in    (s0_div),
        .valid_out (s_valid[0]),
        .ctl_out   (s_ctl[0]),
        .div_out   (s_div[0])
    );

    for (genvar k = 1; k < NSTEP; k++)
    begin : g_step
        xmdu_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (s_valid[k-1]),
            .ctl_in    (s_ctl[k-1]),
            .div_in    (s_div[k-1]),
            .valid_out (s_valid[k]),
            .ctl_out   (s_ctl[k]),
            .div_out   (s_div[k])
        );
    end

    // Final stage: range check, signs, flags
    ctl_t        f_ctl;
    div_t        f_div;
    result_t     result_next;
    result_t     result_reg;
    logic        done_reg;
    logic [15:0] hi;
    logic        ovf;
    logic        qneg;
    logic        range_err;
    logic [16:0] lim;
    logic [15:0] q;
    logic [15:0] r;
    logic        err;

    assign f_ctl = s_ctl[NSTEP-1];
    assign f_div = s_div[NSTEP-1];

    always_comb
    begin
        result_next.acc_out      = f_ctl.ax;
        result_next.ext_out      = f_ctl.dx;
        result_next.flags_out    = f_ctl.flags;
        result_next.divide_error = 1'b0;
        hi   = f_ctl.wide ? f_ctl.prod[31:16] : {8'd0, f_ctl.prod[15:8]};
        qneg = f_ctl.dneg ^ f_ctl.vneg;
        lim  = f_ctl.wide ? 17'h08000 : 17'h00080;
        q    = qneg ? 16'(17'd0 - f_div.quo) : f_div.quo[15:0];
        r    = f_ctl.dneg ? (16'd0 - f_div.rem) : f_div.rem;
        ovf  = 1'b0;
        if (f_ctl.op == OP_DIV)
            range_err = f_ctl.wide ? f_div.quo[16] : (f_div.quo > 17'h000FF);
        else
            range_err = qneg ? (f_div.quo > lim) : (f_div.quo > lim - 17'd1);
        err = f_ctl.bad | range_err;
        unique case (f_ctl.op)
            OP_MUL:
            begin
                ovf = hi != 16'd0;
                result_next.flags_out[FL_CF] = ovf;
                result_next.flags_out[FL_OF] = ovf;
                result_next.flags_out[FL_SF] = f_ctl.wide ? hi[15] : hi[7];
                result_next.flags_out[FL_ZF] = ~ovf;
                result_next.flags_out[FL_PF] = ~(^hi[7:0]);
                result_next.flags_out[FL_AF] = 1'b0;
                result_next.acc_out = f_ctl.prod[15:0];
                if (f_ctl.wide)
                    result_next.ext_out = hi;
            end
            OP_IMUL:
            begin
                ovf = f_ctl.wide ? (f_ctl.prod[31:16] != {16{f_ctl.prod[15]}})
                                 : (f_ctl.prod[15:8] != {8{f_ctl.prod[7]}});
                result_next.flags_out[FL_CF] = ovf;
                result_next.flags_out[FL_OF] = ovf;
                result_next.acc_out = f_ctl.prod[15:0];
                if (f_ctl.wide)
                    result_next.ext_out = f_ctl.prod[31:16];
            end
            OP_DIV, OP_IDIV:
            begin
                result_next.divide_error = err;
                if (!err)
                begin
                    if (f_ctl.wide)
                    begin
                        result_next.acc_out = q;
                        result_next.ext_out = r;
                    end
                    else
                        result_next.acc_out = {r[7:0], q[7:0]};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s_valid[NSTEP-1];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A result beat follows a valid beat at the end of the step chain
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s_valid[NSTEP-1]))
        else $error("result beat without a beat in the last step");

    // A divide error returns the original flags
    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.divide_error |-> result.flags_out == $past(f_ctl.flags))
        else $error("divide error altered the flags");

    // Multiplies never report a divide error
    assert property (@(posedge clk) disable iff (!rst_n)
        s_valid[NSTEP-1] && (f_ctl.op == OP_MUL || f_ctl.op == OP_IMUL)
            |=> !result.divide_error)
        else $error("divide error on a multiply");

endmodule

// File: hdl/xmdu_div_step.sv
// One registered restoring-division step of the multiply/divide pipeline.
// Depends on xmdu_pkg for ctl_t and div_t.
module xmdu_div_step
    import xmdu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic valid_in,
    input  ctl_t ctl_in,
    input  div_t div_in,
    output logic valid_out,
    output ctl_t ctl_out,
    output div_t div_out
);

    logic        valid_reg;
    ctl_t        ctl_reg;
    div_t        div_reg;
    div_t        div_next;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    // Bring down one dividend bit, subtract the divisor where it fits
    always_comb
    begin
        trial    = {div_in.rem, div_in.dsh[16]};
        ge       = trial >= {1'b0, div_in.vm};
        diff     = trial - {1'b0, div_in.vm};
        div_next.rem = ge ? diff[15:0] : trial[15:0];
        div_next.dsh = {div_in.dsh[15:0], 1'b0};
        div_next.quo = {div_in.quo[15:0], ge};
        div_next.vm  = div_in.vm;
    end

    // Clear the valid bit under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        ctl_reg <= ctl_in;
        div_reg <= div_next;
    end

    assign valid_out = valid_reg;
    assign ctl_out   = ctl_reg;
    assign div_out   = div_reg;

endmodule
